@@ rtl/core/clsb_pkg.sv @@
// Shared types, constants and helper functions of the character LCD shadow buffer.
// Used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package clsb_pkg;

    localparam int ROWS_DEF    = 4;
    localparam int COLS_DEF    = 20;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] DIGIT_ZERO   = 8'h30;
    localparam logic [7:0] SET_ADDR_CMD = 8'h80;

    // Opcodes carried in s_tuser.
    typedef enum logic [2:0] {
        OP_LOCATE  = 3'd0,
        OP_PUTCHAR = 3'd1,
        OP_PUTDEC  = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_REFRESH = 3'd4
    } op_t;

    // Commands handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_LOCATE,
        CMD_PUTCHAR,
        CMD_CLEAR,
        CMD_REFRESH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] value;
    } cmd_t;

    typedef enum logic [0:0] {
        FR_IDLE,
        FR_DIGITS
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN_RD,
        BK_SCAN_CMP,
        BK_EMIT_CMD,
        BK_EMIT_DATA,
        BK_FLUSH
    } back_state_t;

    // Decimal expansion: count of characters and the characters, first one in c0.
    typedef struct packed {
        logic [1:0] n;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } dec_t;

    function automatic logic [7:0] row_offset(input logic [1:0] r);
        logic [7:0] off;
        case (r)
            2'd0:    off = 8'h00;
            2'd1:    off = 8'h40;
            2'd2:    off = 8'h14;
            default: off = 8'h54;
        endcase
        return off;
    endfunction

    // Decimal digits of v; tens of the remainder below 100 as r * 205 / 2048.
    function automatic dec_t dec_digits(input logic [7:0] v);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [15:0] p;
        logic [3:0]  t;
        logic [3:0]  o;
        dec_t        d;
        if (v >= 8'd200) begin
            h = 2'd2;
        end else if (v >= 8'd100) begin
            h = 2'd1;
        end else begin
            h = 2'd0;
        end
        r = v - 8'(h) * 8'd100;
        p = 16'(r) * 16'd205;
        t = p[14:11];
        o = 4'(r - 8'(t) * 8'd10);
        if (h != 2'd0) begin
            d.n  = 2'd3;
            d.c0 = DIGIT_ZERO + 8'(h);
            d.c1 = DIGIT_ZERO + 8'(t);
            d.c2 = DIGIT_ZERO + 8'(o);
        end else if (t != 4'd0) begin
            d.n  = 2'd2;
            d.c0 = DIGIT_ZERO + 8'(t);
            d.c1 = DIGIT_ZERO + 8'(o);
            d.c2 = DIGIT_ZERO;
        end else begin
            d.n  = 2'd1;
            d.c0 = DIGIT_ZERO + 8'(o);
            d.c1 = DIGIT_ZERO;
            d.c2 = DIGIT_ZERO;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/clsb_front.sv @@
// Front end: accepts input transactions, decodes the opcode and expands put decimal
// into single-character commands for the queue. Depends on clsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clsb_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [23:0]         s_tdata,   // col [7:0], row [15:8], value [23:16]
    input  wire  [2:0]          s_tuser,   // opcode [2:0]
    output logic                push_valid,
    input  wire                 push_ready,
    output clsb_pkg::cmd_t      push_data
);
    import clsb_pkg::*;

    front_state_t state_reg, state_next;
    logic [7:0]   dig0_reg, dig0_next;
    logic [7:0]   dig1_reg, dig1_next;
    logic [7:0]   dig2_reg, dig2_next;
    logic [1:0]   left_reg, left_next;

    logic [7:0] in_col;
    logic [7:0] in_row;
    logic [7:0] in_value;
    logic       accept;
    dec_t       dec;

    assign in_col   = s_tdata[7:0];
    assign in_row   = s_tdata[15:8];
    assign in_value = s_tdata[23:16];
    assign dec      = dec_digits(in_value);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (accept && s_tuser == OP_PUTDEC) begin
                    state_next = FR_DIGITS;
                end
            end
            FR_DIGITS: begin
                if (push_ready && left_reg == 2'd1) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        push_valid = 1'b0;
        push_data  = '{kind: CMD_LOCATE, col: in_col, row: in_row, value: in_value};
        dig0_next  = dig0_reg;
        dig1_next  = dig1_reg;
        dig2_next  = dig2_reg;
        left_next  = left_reg;
        unique case (state_reg)
            FR_IDLE: begin
                s_tready = push_ready;
                unique case (s_tuser)
                    OP_LOCATE: begin
                        push_valid     = s_tvalid;
                        push_data.kind = CMD_LOCATE;
                    end
                    OP_PUTCHAR: begin
                        push_valid     = s_tvalid;
                        push_data.kind = CMD_PUTCHAR;
                    end
                    OP_PUTDEC: begin
                        if (accept) begin
                            dig0_next = dec.c0;
                            dig1_next = dec.c1;
                            dig2_next = dec.c2;
                            left_next = dec.n;
                        end
                    end
                    OP_CLEAR: begin
                        push_valid     = s_tvalid;
                        push_data.kind = CMD_CLEAR;
                    end
                    OP_REFRESH: begin
                        push_valid     = s_tvalid;
                        push_data.kind = CMD_REFRESH;
                    end
                    default: begin
                        push_valid = 1'b0;
                    end
                endcase
            end
            FR_DIGITS: begin
                push_valid      = 1'b1;
                push_data.kind  = CMD_PUTCHAR;
                push_data.value = dig0_reg;
                if (push_ready) begin
                    dig0_next = dig1_reg;
                    dig1_next = dig2_reg;
                    left_next = left_reg - 2'd1;
                end
            end
            default: begin
                push_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            left_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        dig0_reg <= dig0_next;
        dig1_reg <= dig1_next;
        dig2_reg <= dig2_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/clsb_fifo.sv @@
// Short command queue between the front end and the back end.
// Entries are clsb_pkg::cmd_t; depth comes from clsb_pkg::QUEUE_DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module clsb_fifo (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push_valid,
    output logic                push_ready,
    input  clsb_pkg::cmd_t      push_data,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output clsb_pkg::cmd_t      pop_data
);
    import clsb_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = count_reg != NW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + NW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NW'(QUEUE_DEPTH))
        else $error("command queue count beyond depth");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + NW'(1))
        else $error("command queue count did not follow a push");

endmodule

`default_nettype wire

@@ rtl/core/clsb_back.sv @@
// Back end: owns the frame buffer, the shadow buffer and the cursor, executes queued
// commands and walks a row on refresh. Depends on clsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clsb_back #(
    parameter int ROWS_N = clsb_pkg::ROWS_DEF,
    parameter int COLS_N = clsb_pkg::COLS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 pop_valid,
    output logic                pop_ready,
    input  clsb_pkg::cmd_t      pop_data,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [7:0]          m_tdata,   // lcd_byte [7:0]
    output logic [0:0]          m_tuser,   // is_data [0]
    output logic                m_tlast
);
    import clsb_pkg::*;

    localparam int CELLS = ROWS_N * COLS_N;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = (COLS_N > 1) ? $clog2(COLS_N) : 1;
    localparam int RW    = (ROWS_N > 1) ? $clog2(ROWS_N) : 1;

    // Cells whose valid bit is clear read as a space; clear only drops the frame bits.
    logic [7:0]       fb_mem [CELLS];
    logic [7:0]       sh_mem [CELLS];
    logic [CELLS-1:0] fb_valid_reg, fb_valid_next;
    logic [CELLS-1:0] sh_valid_reg, sh_valid_next;
    logic [7:0]       fb_q;
    logic [7:0]       sh_q;
    logic             fbv_q;
    logic             shv_q;

    back_state_t   state_reg, state_next;
    logic [7:0]    cur_col_reg, cur_col_next;
    logic [7:0]    cur_row_reg, cur_row_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] x_reg, x_next;
    logic [7:0]    cmd_base_reg, cmd_base_next;
    logic          in_run_reg, in_run_next;

    // One byte is held back so that the final byte of a row can carry tlast.
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_byte_reg, pend_byte_next;
    logic          pend_data_reg, pend_data_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_byte_reg, m_byte_next;
    logic          m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    logic          cur_in_range;
    logic [AW-1:0] cur_addr;
    logic          row_ok;
    logic          x_last;
    logic [7:0]    fb_byte;
    logic [7:0]    sh_byte;
    logic          out_free;
    logic          prod_ok;
    logic          fb_we;
    logic          sh_we;

    assign cur_in_range = (cur_col_reg < 8'(COLS_N)) && (cur_row_reg < 8'(ROWS_N));
    assign cur_addr     = AW'(cur_row_reg[RW-1:0]) * AW'(COLS_N) + AW'(cur_col_reg[CW-1:0]);
    assign row_ok       = pop_data.row < 8'(ROWS_N);
    assign x_last       = x_reg == CW'(COLS_N - 1);
    assign fb_byte      = fbv_q ? fb_q : SPACE_CHAR;
    assign sh_byte      = shv_q ? sh_q : SPACE_CHAR;
    assign out_free     = !m_tvalid_reg || m_tready;
    assign prod_ok      = !pend_valid_reg || out_free;
    assign fb_we        = state_reg == BK_IDLE && pop_valid && pop_data.kind == CMD_PUTCHAR
                          && cur_in_range;
    assign sh_we        = state_reg == BK_EMIT_DATA && prod_ok;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (pop_valid && pop_data.kind == CMD_REFRESH && row_ok) begin
                    state_next = BK_SCAN_RD;
                end
            end
            BK_SCAN_RD: begin
                state_next = BK_SCAN_CMP;
            end
            BK_SCAN_CMP: begin
                if (fb_byte != sh_byte) begin
                    state_next = in_run_reg ? BK_EMIT_DATA : BK_EMIT_CMD;
                end else begin
                    state_next = x_last ? BK_FLUSH : BK_SCAN_RD;
                end
            end
            BK_EMIT_CMD: begin
                if (prod_ok) begin
                    state_next = BK_EMIT_DATA;
                end
            end
            BK_EMIT_DATA: begin
                if (prod_ok) begin
                    state_next = x_last ? BK_FLUSH : BK_SCAN_RD;
                end
            end
            BK_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop_ready       = 1'b0;
        fb_valid_next   = fb_valid_reg;
        sh_valid_next   = sh_valid_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        addr_next       = addr_reg;
        x_next          = x_reg;
        cmd_base_next   = cmd_base_reg;
        in_run_next     = in_run_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_data_next  = pend_data_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_byte_next     = m_byte_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        unique case (state_reg)
            BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    case (pop_data.kind)
                        CMD_LOCATE: begin
                            cur_col_next = pop_data.col;
                            cur_row_next = pop_data.row;
                        end
                        CMD_PUTCHAR: begin
                            if (cur_in_range) begin
                                fb_valid_next[cur_addr] = 1'b1;
                                if (cur_col_reg == 8'(COLS_N - 1)) begin
                                    cur_col_next = 8'd0;
                                    cur_row_next = (cur_row_reg == 8'(ROWS_N - 1)) ?
                                                   8'd0 : cur_row_reg + 8'd1;
                                end else begin
                                    cur_col_next = cur_col_reg + 8'd1;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            fb_valid_next = '0;
                            cur_col_next  = 8'd0;
                            cur_row_next  = 8'd0;
                        end
                        default: begin
                            addr_next     = AW'(pop_data.row[RW-1:0]) * AW'(COLS_N);
                            x_next        = '0;
                            in_run_next   = 1'b0;
                            cmd_base_next = SET_ADDR_CMD + row_offset(pop_data.row[1:0]);
                        end
                    endcase
                end
            end
            BK_SCAN_RD: begin
                pop_ready = 1'b0;
            end
            BK_SCAN_CMP: begin
                if (fb_byte == sh_byte) begin
                    in_run_next = 1'b0;
                    if (!x_last) begin
                        x_next    = x_reg + CW'(1);
                        addr_next = addr_reg + AW'(1);
                    end
                end
            end
            BK_EMIT_CMD: begin
                if (prod_ok) begin
                    if (pend_valid_reg) begin
                        m_tvalid_next = 1'b1;
                        m_byte_next   = pend_byte_reg;
                        m_data_next   = pend_data_reg;
                        m_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_byte_next  = cmd_base_reg + 8'(x_reg);
                    pend_data_next  = 1'b0;
                end
            end
            BK_EMIT_DATA: begin
                if (prod_ok) begin
                    if (pend_valid_reg) begin
                        m_tvalid_next = 1'b1;
                        m_byte_next   = pend_byte_reg;
                        m_data_next   = pend_data_reg;
                        m_last_next   = 1'b0;
                    end
                    pend_valid_next        = 1'b1;
                    pend_byte_next         = fb_byte;
                    pend_data_next         = 1'b1;
                    sh_valid_next[addr_reg] = 1'b1;
                    in_run_next            = 1'b1;
                    if (!x_last) begin
                        x_next    = x_reg + CW'(1);
                        addr_next = addr_reg + AW'(1);
                    end
                end
            end
            BK_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_byte_next     = pend_byte_reg;
                    m_data_next     = pend_data_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            fb_valid_reg   <= '0;
            sh_valid_reg   <= '0;
            cur_col_reg    <= 8'd0;
            cur_row_reg    <= 8'd0;
            in_run_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fb_valid_reg   <= fb_valid_next;
            sh_valid_reg   <= sh_valid_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            in_run_reg     <= in_run_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        x_reg         <= x_next;
        cmd_base_reg  <= cmd_base_next;
        pend_byte_reg <= pend_byte_next;
        pend_data_reg <= pend_data_next;
        m_byte_reg    <= m_byte_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    // Buffer memories: one write port each, registered read at the scan address.
    always_ff @(posedge aclk) begin
        if (fb_we) begin
            fb_mem[cur_addr] <= pop_data.value;
        end
        if (sh_we) begin
            sh_mem[addr_reg] <= fb_byte;
        end
        fb_q  <= fb_mem[addr_reg];
        sh_q  <= sh_mem[addr_reg];
        fbv_q <= fb_valid_reg[addr_reg];
        shv_q <= sh_valid_reg[addr_reg];
    end

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_IDLE |-> !pend_valid_reg)
        else $error("byte left pending after a refresh finished");

    a_scan_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_SCAN_CMP |-> 32'(addr_reg) < 32'(CELLS))
        else $error("scan address beyond the buffer");

endmodule

`default_nettype wire

@@ rtl/core/char_lcd_shadow_buffer_refresh.sv @@
// Character LCD shadow buffer with per-row refresh: front end, command queue and back end.
// Depends on clsb_pkg, clsb_front, clsb_fifo and clsb_back.
//
// Writes to the frame buffer (locate, put char, put decimal, clear) produce no output;
// a refresh row transaction compares one row with the shadow copy of the display and
// sends a set-address command followed by the data bytes for every run of changed cells,
// with tlast on the final byte of that row. The front end takes one transaction a cycle
// while the four-entry queue has room and no put decimal is being expanded; put decimal
// then pushes its digits into the queue one after another. The back end executes locate,
// put char and clear in its idle state as it takes them; a refresh takes the command, then
// for each column makes a registered read of both buffers and a compare, emits the bytes
// for changed cells and finally releases the held-back last byte, and it can stall while
// m_tready is low. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_shadow_buffer_refresh #(
    parameter int ROWS_N = clsb_pkg::ROWS_DEF,
    parameter int COLS_N = clsb_pkg::COLS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // col [7:0], row [15:8], value [23:16]
    input  wire  [2:0]  s_tuser,   // opcode [2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // lcd_byte [7:0]
    output logic [0:0]  m_tuser,   // is_data [0]
    output logic        m_tlast
);
    import clsb_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    clsb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    clsb_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    clsb_back #(
        .ROWS_N (ROWS_N),
        .COLS_N (COLS_N)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the character LCD shadow buffer with per-row refresh.
// Depends on clsb_pkg and char_lcd_shadow_buffer_refresh; predicts every refresh byte itself.
`timescale 1ns / 1ps

module tb_top;
    import clsb_pkg::*;

    localparam int ROWS          = ROWS_DEF;
    localparam int COLS          = COLS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 300;
    localparam int REPORT_MAX    = 10;
    localparam int GAP_MAX       = 60;

    // Opcodes that the block must ignore.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       last;
    } lcd_out_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // col [7:0], row [15:8], value [23:16]
    logic [2:0]  s_tuser;   // opcode [2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // lcd_byte [7:0]
    logic [0:0]  m_tuser;   // is_data [0]
    logic        m_tlast;

    idle_mode_t idle_mode = IDLE_NONE;
    int         fail_count = 0;
    int         cycle_count = 0;

    // Local copy of the display state.
    logic [7:0] frame_img [ROWS*COLS];
    logic [7:0] shown_img [ROWS*COLS];
    logic [7:0] cur_col;
    logic [7:0] cur_row;
    lcd_out_t   lcd_expect_q [$];

    char_lcd_shadow_buffer_refresh DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [7:0] ddram_row_base(input logic [7:0] r);
        logic [7:0] base;
        case (r[1:0])
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            default: base = 8'h54;
        endcase
        return base;
    endfunction

    function automatic void display_model_reset();
        for (int i = 0; i < ROWS * COLS; i++) begin
            frame_img[i] = SPACE_CHAR;
            shown_img[i] = SPACE_CHAR;
        end
        cur_col = 8'd0;
        cur_row = 8'd0;
    endfunction

    function automatic void write_cell_at_cursor(input logic [7:0] ch);
        if (cur_col < COLS && cur_row < ROWS) begin
            frame_img[cur_row * COLS + cur_col] = ch;
            cur_col = cur_col + 8'd1;
            if (cur_col == COLS) begin
                cur_col = 8'd0;
                cur_row = cur_row + 8'd1;
                if (cur_row == ROWS) begin
                    cur_row = 8'd0;
                end
            end
        end
    endfunction

    function automatic void write_decimal(input logic [7:0] v);
        int hundreds;
        int tens;
        int ones;
        hundreds = v / 100;
        tens     = (v / 10) % 10;
        ones     = v % 10;
        if (hundreds != 0) begin
            write_cell_at_cursor(8'h30 + 8'(hundreds));
        end
        if (hundreds != 0 || tens != 0) begin
            write_cell_at_cursor(8'h30 + 8'(tens));
        end
        write_cell_at_cursor(8'h30 + 8'(ones));
    endfunction

    // Each run of changed cells costs one set-address command and then its data bytes.
    function automatic void predict_row_refresh(input logic [7:0] r);
        bit       in_run;
        int       idx;
        int       first_new;
        lcd_out_t item;
        in_run    = 1'b0;
        first_new = lcd_expect_q.size();
        if (r < ROWS) begin
            for (int x = 0; x < COLS; x++) begin
                idx = r * COLS + x;
                if (frame_img[idx] != shown_img[idx]) begin
                    if (!in_run) begin
                        item.lcd_byte = SET_ADDR_CMD + ddram_row_base(r) + 8'(x);
                        item.is_data  = 1'b0;
                        item.last     = 1'b0;
                        lcd_expect_q.push_back(item);
                    end
                    item.lcd_byte = frame_img[idx];
                    item.is_data  = 1'b1;
                    item.last     = 1'b0;
                    lcd_expect_q.push_back(item);
                    shown_img[idx] = frame_img[idx];
                    in_run = 1'b1;
                end else begin
                    in_run = 1'b0;
                end
            end
            if (lcd_expect_q.size() > first_new) begin
                item = lcd_expect_q.pop_back();
                item.last = 1'b1;
                lcd_expect_q.push_back(item);
            end
        end
    endfunction

    function automatic void display_model_apply(input logic [2:0] opcode, input logic [7:0] col,
                                                 input logic [7:0] row, input logic [7:0] value);
        case (opcode)
            OP_LOCATE: begin
                cur_col = col;
                cur_row = row;
            end
            OP_PUTCHAR: begin
                write_cell_at_cursor(value);
            end
            OP_PUTDEC: begin
                write_decimal(value);
            end
            OP_CLEAR: begin
                for (int i = 0; i < ROWS * COLS; i++) begin
                    frame_img[i] = SPACE_CHAR;
                end
                cur_col = 8'd0;
                cur_row = 8'd0;
            end
            OP_REFRESH: begin
                predict_row_refresh(row);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int sender_idle_pct();
        int pct;
        case (idle_mode)
            IDLE_SENDER: pct = 85;
            IDLE_BOTH:   pct = 13;
            default:     pct = 0;
        endcase
        return pct;
    endfunction

    function automatic int receiver_stall_pct();
        int pct;
        case (idle_mode)
            IDLE_RECEIVER: pct = 85;
            IDLE_BOTH:     pct = 13;
            default:       pct = 0;
        endcase
        return pct;
    endfunction

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    always @(posedge aclk) begin
        lcd_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (lcd_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("unexpected transaction: byte %02h data %0b last %0b",
                             m_tdata, m_tuser[0], m_tlast);
                end
            end else begin
                want = lcd_expect_q.pop_front();
                if (m_tdata !== want.lcd_byte || m_tuser[0] !== want.is_data ||
                    m_tlast !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 want.lcd_byte, want.is_data, want.last,
                                 m_tdata, m_tuser[0], m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] opcode, input logic [7:0] col,
                             input logic [7:0] row, input logic [7:0] value);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < sender_idle_pct()) begin
            gap++;
        end
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= opcode;
        s_tdata  <= {value, row, col};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        display_model_apply(opcode, col, row, value);
    endtask

    // Holds the sender back until every predicted byte has gone out and the block is quiet.
    task automatic wait_for_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (lcd_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_refresh_after_reset();
        idle_mode = IDLE_NONE;
        for (int r = 0; r < ROWS; r++) begin
            send_item(OP_REFRESH, 8'h00, 8'(r), 8'h00);
        end
        wait_for_idle();
    endtask

    task automatic test_directed_cases();
        idle_mode = IDLE_NONE;
        send_item(OP_PUTCHAR, 8'h00, 8'h00, 8'hFF);
        send_item(OP_PUTDEC,  8'hFF, 8'hFF, 8'd255);
        send_item(OP_PUTDEC,  8'h00, 8'h00, 8'd0);
        send_item(OP_PUTDEC,  8'h00, 8'h00, 8'd10);
        send_item(OP_REFRESH, 8'h00, 8'h00, 8'h00);
        // Last cell of the last row, so the cursor wraps to the top-left corner.
        send_item(OP_LOCATE,  8'(COLS - 1), 8'(ROWS - 1), 8'h00);
        send_item(OP_PUTCHAR, 8'h00, 8'h00, 8'h00);
        send_item(OP_PUTCHAR, 8'h00, 8'h00, 8'h41);
        send_item(OP_REFRESH, 8'h00, 8'(ROWS - 1), 8'h00);
        send_item(OP_REFRESH, 8'h00, 8'h00, 8'h00);
        // A cursor outside the buffer drops every character.
        send_item(OP_LOCATE,  8'hFF, 8'hFF, 8'h00);
        send_item(OP_PUTCHAR, 8'h00, 8'h00, 8'h5A);
        send_item(OP_PUTDEC,  8'h00, 8'h00, 8'd99);
        send_item(OP_LOCATE,  8'(COLS), 8'h00, 8'h00);
        send_item(OP_PUTCHAR, 8'h00, 8'h00, 8'h5A);
        send_item(OP_REFRESH, 8'h00, 8'hFF, 8'h00);
        send_item(OP_REFRESH, 8'h00, 8'(ROWS), 8'h00);
        send_item(OP_SPARE_FIRST, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_SPARE_FIRST + 3'd1, 8'hFF, 8'h00, 8'hFF);
        send_item(OP_SPARE_LAST, 8'hFF, 8'h01, 8'hFF);
        send_item(OP_CLEAR,   8'hFF, 8'hFF, 8'hFF);
        send_item(OP_REFRESH, 8'h00, 8'h00, 8'h00);
        send_item(OP_REFRESH, 8'h00, 8'(ROWS - 1), 8'h00);
        send_item(OP_LOCATE,  8'd5, 8'd2, 8'h00);
        send_item(OP_PUTDEC,  8'h00, 8'h00, 8'd7);
        send_item(OP_REFRESH, 8'h00, 8'd2, 8'h00);
        wait_for_idle();
    endtask

    task automatic test_random_traffic(input idle_mode_t mode, input int n_items);
        int         done;
        int         pick;
        logic [2:0] op;
        logic [7:0] c;
        logic [7:0] r;
        logic [7:0] v;
        idle_mode = mode;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            c = 8'($urandom_range(255));
            r = 8'($urandom_range(255));
            v = 8'($urandom_range(255));
            if (pick < 15) begin
                op = OP_LOCATE;
                if ($urandom_range(4) != 0) begin
                    c = 8'($urandom_range(COLS - 1));
                    r = 8'($urandom_range(ROWS - 1));
                end
            end else if (pick < 45) begin
                op = OP_PUTCHAR;
            end else if (pick < 60) begin
                op = OP_PUTDEC;
            end else if (pick < 62) begin
                op = OP_CLEAR;
            end else if (pick < 95) begin
                op = OP_REFRESH;
                if ($urandom_range(9) != 0) begin
                    r = 8'($urandom_range(ROWS - 1));
                end
            end else begin
                op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            end
            send_item(op, c, r, v);
            if (op <= OP_REFRESH) begin
                done++;
            end
        end
        wait_for_idle();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        display_model_reset();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_refresh_after_reset();
        test_directed_cases();
        test_random_traffic(IDLE_NONE, 80);
        test_random_traffic(IDLE_SENDER, 80);
        test_random_traffic(IDLE_RECEIVER, 85);
        test_random_traffic(IDLE_BOTH, 85);

        if (fail_count == 0 && lcd_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/clsb_pkg.sv
rtl/core/clsb_front.sv
rtl/core/clsb_fifo.sv
rtl/core/clsb_back.sv
rtl/core/char_lcd_shadow_buffer_refresh.sv
verif/tb_top.sv
